>>> src/tbp_pkg.sv
`timescale 1ns / 1ps

package tbp_pkg;

    // Field and register widths
    localparam int ELAPSED_W = 32;
    localparam int PKT_W     = 16;
    localparam int RATE_W    = 28;
    localparam int BURST_W   = 16;
    localparam int WAIT_W    = 30;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 3;

    // Fixed-point formats
    localparam int TBP_FRAC_BITS = 24;
    localparam int RATE_FRAC     = 24;

    // Register reset values
    localparam logic [RATE_W-1:0]  RATE_RESET  = 28'd2097152;
    localparam logic [BURST_W-1:0] BURST_RESET = 16'd9015;

    // Register map, byte address bit 2 selects the register
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_BURST = 1'b1;

    // Retry wait limit
    localparam logic [WAIT_W-1:0] MAX_WAIT = 30'd1000000000;
    localparam logic [WAIT_W-1:0] MIN_WAIT = 30'd1;

    // Divide by three through a reciprocal: exact for 17-bit dividends
    localparam int               X_W      = PKT_W + 1;
    localparam int               X3_W     = X_W + 16;
    localparam logic [15:0]      RECIP3   = 16'd43691;

    // Quotient bits produced by the restoring divider, one per cycle
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_REFILL,
        S_DECIDE,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_FIN,
        S_OUT
    } tbp_state_t;

    typedef struct packed {
        logic capture;
        logic multiply;
        logic refill;
        logic decide;
        logic prepare;
        logic check;
        logic div_step;
        logic finish;
        logic write_out;
    } tbp_cmd_t;

    typedef struct packed {
        logic reset_item;
        logic covers;
        logic no_divide;
    } tbp_status_t;

endpackage

>>> src/tbp_ctrl.sv
`timescale 1ns / 1ps

module tbp_ctrl import tbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  tbp_status_t status,
    output tbp_cmd_t    cmd
);

    tbp_state_t       state_reg;
    tbp_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             accept;

    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = status.reset_item ? S_OUT : S_REFILL;
            end
            S_REFILL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = status.covers ? S_OUT : S_PREP;
            end
            S_PREP:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.no_divide ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cnt_next       = '0;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = accept;
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            S_PREP:
            begin
                cmd.prepare = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                // Wrap to zero on the last step
                if (cnt_reg != CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
            end
            S_OUT:
            begin
                cmd.write_out = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_cnt_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> state_reg == S_DIV)
        else $error("divide counter active outside divide state");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result valid raised outside output state");

    a_out_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && !out_ready |=> state_reg == S_OUT)
        else $error("result dropped while previous word unread");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && !in_valid |=> state_reg == S_IDLE)
        else $error("left idle without an input word");

endmodule

>>> src/tbp_datapath.sv
`timescale 1ns / 1ps

module tbp_datapath import tbp_pkg::*;
#(
    parameter int FRAC_BITS = TBP_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbp_cmd_t             cmd,
    output tbp_status_t          status,
    input  logic [RATE_W-1:0]    rate,
    input  logic [BURST_W-1:0]   burst,
    input  logic                 req_type,
    input  logic [ELAPSED_W-1:0] elapsed_ns,
    input  logic [PKT_W-1:0]     pkt_len,
    output logic                 granted,
    output logic [WAIT_W-1:0]    wait_ns,
    output logic                 spin_mode,
    output logic [PKT_W-1:0]     tokens_whole
);

    localparam int LVL_W  = PKT_W + FRAC_BITS;
    localparam int SH_UP  = (FRAC_BITS > RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
    localparam int SH_DN  = (FRAC_BITS < RATE_FRAC) ? RATE_FRAC - FRAC_BITS : 0;
    localparam int PROD_W = ELAPSED_W + RATE_W;
    localparam int ADD_W  = PROD_W + SH_UP;
    localparam int NUM_W  = LVL_W + SH_DN;
    localparam int DEN_W  = RATE_W + SH_UP;
    localparam int QUO_W  = DIV_STEPS;
    localparam int D_W    = DEN_W + QUO_W - 1;
    localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam logic [LVL_W-1:0] THIRD1 = LVL_W'((65'd1 << FRAC_BITS) / 3);
    localparam logic [LVL_W-1:0] THIRD2 = LVL_W'((65'd2 << FRAC_BITS) / 3);
    localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(BURST_RESET) << FRAC_BITS;

    logic                 req_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PKT_W-1:0]     pkt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PKT_W-1:0]     cap_reg;
    logic [X3_W-1:0]      x3_reg;
    logic [LVL_W-1:0]     level_reg;
    logic [LVL_W-1:0]     level_next;
    logic [15:0]          q0_reg;
    logic [1:0]           r0_reg;
    logic [LVL_W-1:0]     two_thirds_reg;
    logic                 granted_reg;
    logic                 spin_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [D_W-1:0]       d_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 out_granted_reg;
    logic [WAIT_W-1:0]    out_wait_reg;
    logic                 out_spin_reg;
    logic [PKT_W-1:0]     out_tokens_reg;

    logic [PKT_W-1:0]     cap_w;
    logic [X_W-1:0]       x_w;
    logic [X_W-1:0]       xr_w;
    logic [LVL_W-1:0]     cap_q;
    logic [LVL_W-1:0]     pkt_q;
    logic [ADD_W-1:0]     add_w;
    logic [LVL_W-1:0]     room_w;
    logic [15:0]          q0_w;
    logic [1:0]           r0_w;
    logic [LVL_W-1:0]     third_w;
    logic [LVL_W-1:0]     target_w;
    logic [LVL_W-1:0]     missing_w;
    logic                 covers;
    logic                 no_divide;
    logic [CMP_W-1:0]     rem_ext;
    logic [CMP_W-1:0]     d_ext;
    logic                 take;
    logic [31:0]          quo_inc;
    logic [WAIT_W-1:0]    wait_fin;

    assign cap_w   = (burst > pkt_reg) ? burst : pkt_reg;
    assign x_w     = {cap_w, 1'b0};
    assign xr_w    = {cap_reg, 1'b0};
    assign cap_q   = LVL_W'(cap_reg) << FRAC_BITS;
    assign pkt_q   = LVL_W'(pkt_reg) << FRAC_BITS;
    assign add_w   = (ADD_W'(prod_reg) << SH_UP) >> SH_DN;
    assign room_w  = cap_q - level_reg;
    assign q0_w    = x3_reg[X3_W-1:X_W];
    assign r0_w    = 2'(xr_w - ({q0_w, 1'b0} + {1'b0, q0_w}));

    // Fraction of 2*cap_q/3 left over by the whole-byte quotient
    always_comb
    begin
        case (r0_reg)
            2'd1:    third_w = THIRD1;
            2'd2:    third_w = THIRD2;
            default: third_w = '0;
        endcase
    end

    assign target_w  = (pkt_q > two_thirds_reg) ? pkt_q : two_thirds_reg;
    assign missing_w = target_w - level_reg;
    assign covers    = level_reg >= pkt_q;
    assign no_divide = (rate == '0) ||
                       (CMP_W'(num_reg) >= (CMP_W'(den_reg) << QUO_W));

    assign rem_ext = CMP_W'(rem_reg);
    assign d_ext   = CMP_W'(d_reg);
    assign take    = rem_ext >= d_ext;

    // Round up, then clamp
    assign quo_inc  = 32'(quo_reg) + 32'(rem_reg != '0);
    assign wait_fin = (quo_inc > 32'(MAX_WAIT)) ? MAX_WAIT :
                      (quo_inc == '0) ? MIN_WAIT : WAIT_W'(quo_inc);

    assign status.reset_item = req_reg;
    assign status.covers     = covers;
    assign status.no_divide  = no_divide;

    always_comb
    begin
        level_next = level_reg;
        if (cmd.multiply && req_reg)
        begin
            level_next = LVL_W'(burst) << FRAC_BITS;
        end
        else if (cmd.refill && elapsed_reg != '0)
        begin
            if (level_reg >= cap_q || add_w >= ADD_W'(room_w))
            begin
                level_next = cap_q;
            end
            else
            begin
                level_next = level_reg + LVL_W'(add_w);
            end
        end
        else if (cmd.decide && covers)
        begin
            level_next = level_reg - pkt_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= req_type;
            elapsed_reg <= elapsed_ns;
            pkt_reg     <= pkt_len;
        end
        if (cmd.multiply)
        begin
            prod_reg    <= PROD_W'(elapsed_reg) * PROD_W'(rate);
            cap_reg     <= cap_w;
            x3_reg      <= X3_W'(x_w) * X3_W'(RECIP3);
            granted_reg <= 1'b0;
            spin_reg    <= 1'b0;
            wait_reg    <= '0;
        end
        if (cmd.refill)
        begin
            q0_reg <= q0_w;
            r0_reg <= r0_w;
        end
        if (cmd.decide)
        begin
            granted_reg    <= covers;
            spin_reg       <= {pkt_reg, 1'b0} > {1'b0, cap_reg};
            two_thirds_reg <= (LVL_W'(q0_reg) << FRAC_BITS) + third_w;
        end
        if (cmd.prepare)
        begin
            num_reg <= NUM_W'(missing_w) << SH_DN;
            den_reg <= DEN_W'(rate) << SH_UP;
        end
        if (cmd.check)
        begin
            rem_reg <= num_reg;
            d_reg   <= D_W'(den_reg) << (QUO_W - 1);
            quo_reg <= '0;
            if (no_divide)
            begin
                wait_reg <= MAX_WAIT;
            end
        end
        if (cmd.div_step)
        begin
            if (take)
            begin
                rem_reg <= NUM_W'(rem_ext - d_ext);
            end
            quo_reg <= {quo_reg[QUO_W-2:0], take};
            d_reg   <= d_reg >> 1;
        end
        if (cmd.finish)
        begin
            wait_reg <= wait_fin;
        end
        if (cmd.write_out)
        begin
            out_granted_reg <= granted_reg;
            out_wait_reg    <= wait_reg;
            out_spin_reg    <= spin_reg;
            out_tokens_reg  <= level_reg[FRAC_BITS +: PKT_W];
        end
    end

    assign granted      = out_granted_reg;
    assign wait_ns      = out_wait_reg;
    assign spin_mode    = out_spin_reg;
    assign tokens_whole = out_tokens_reg;

endmodule

>>> src/token_bucket_pacer.sv
`timescale 1ns / 1ps

// Token-bucket packet pacer.
// Input channel (in_valid/in_ready): one word per send request or bucket
// reset, with the nanoseconds elapsed since the previous word and the packet
// size. Output channel (out_valid/out_ready): exactly one result word per
// input word: grant flag, retry wait in ns, spin flag and whole token bytes.
// Configuration: APB-style port, rate at byte address 0, burst at address 4;
// write only while no word is in flight. pready is tied high.
// Timing: one word at a time; a new word is taken only back in idle, after
// the result register is loaded. A bucket reset passes through multiply and
// output; a grant through multiply, refill, decide and output; a refusal that
// clamps at once (zero rate or very long wait) adds prepare and check; and a
// refusal that runs the restoring divider adds the divide steps and finish,
// with the divider retiring one quotient bit per cycle.
// Reset: tokens load 9015 bytes, rate 0.125 B/ns, no result pending.
// Stall: the result register holds a finished word while the block takes
// and works on the next; that next result waits in the output state until
// the receiver drains the register.

module token_bucket_pacer import tbp_pkg::*;
#(
    parameter int FRAC_BITS = TBP_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [CFG_W-1:0]     pwdata,
    output logic [CFG_W-1:0]     prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [ELAPSED_W-1:0] elapsed_ns,
    input  logic [PKT_W-1:0]     pkt_len,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 granted,
    output logic [WAIT_W-1:0]    wait_ns,
    output logic                 spin_mode,
    output logic [PKT_W-1:0]     tokens_whole
);

    logic [RATE_W-1:0]  rate_reg;
    logic [RATE_W-1:0]  rate_next;
    logic [BURST_W-1:0] burst_reg;
    logic [BURST_W-1:0] burst_next;
    logic               cfg_write;
    tbp_cmd_t           cmd;
    tbp_status_t        status;

    // Register file: write on the access phase, bit 2 of the address picks
    // the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        rate_next  = rate_reg;
        burst_next = burst_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_RATE:  rate_next  = pwdata[RATE_W-1:0];
                REG_BURST: burst_next = pwdata[BURST_W-1:0];
                default:   rate_next  = rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end
        else
        begin
            rate_reg  <= rate_next;
            burst_reg <= burst_next;
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        case (paddr[2])
            REG_RATE:  prdata = CFG_W'(rate_reg);
            REG_BURST: prdata = CFG_W'(burst_reg);
            default:   prdata = '0;
        endcase
    end

    // Sequencer: steps each word through refill, decision and division as it needs them
    tbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Token arithmetic, divider and result register
    tbp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rate         (rate_reg),
        .burst        (burst_reg),
        .req_type     (req_type),
        .elapsed_ns   (elapsed_ns),
        .pkt_len      (pkt_len),
        .granted      (granted),
        .wait_ns      (wait_ns),
        .spin_mode    (spin_mode),
        .tokens_whole (tokens_whole)
    );

endmodule

>>> tb/sv/token_bucket_pacer_tb.sv
`timescale 1ns / 1ps

module token_bucket_pacer_tb;
    import tbp_pkg::*;

    // Request codes carried by req_type
    localparam logic REQ_SEND  = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    // Token level holds whole bytes above FRAC_BITS fraction bits
    localparam int LEVEL_W = PKT_W + TBP_FRAC_BITS;

    // Cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // Cycles to let pass once the last result is in
    localparam int TAIL_CYCLES = 50;

    typedef struct packed {
        logic              granted;
        logic [WAIT_W-1:0] wait_ns;
        logic              spin;
        logic [PKT_W-1:0]  tokens;
    } pacer_result_t;

    // Bucket predictor plus the queue of results it has worked out
    class pacer_scoreboard;
        logic [RATE_W-1:0]  rate;
        logic [BURST_W-1:0] burst;
        logic [LEVEL_W-1:0] level;
        logic [WAIT_W-1:0]  last_wait;
        pacer_result_t      pending_results[$];
        int                 errors;

        function new();
            rate      = RATE_RESET;
            burst     = BURST_RESET;
            level     = LEVEL_W'(BURST_RESET) << TBP_FRAC_BITS;
            last_wait = '0;
            errors    = 0;
        endfunction

        function void compare(string what, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, exp_v,
                         act_v);
            end
        endfunction

        // Advance the bucket by one accepted word and queue the result it yields
        function void pace_word(logic req, logic [ELAPSED_W-1:0] el, logic [PKT_W-1:0] pkt);
            pacer_result_t r;
            logic [63:0]   lvl;
            logic [63:0]   cap;
            logic [63:0]   cap_q;
            logic [63:0]   pkt_q;
            logic [63:0]   add;
            logic [63:0]   two_thirds;
            logic [63:0]   target;
            logic [63:0]   num;
            logic [63:0]   quo;
            r   = '0;
            lvl = 64'(level);
            if (req == REQ_RESET)
            begin
                lvl = 64'(burst) << TBP_FRAC_BITS;
            end
            else
            begin
                cap   = (64'(burst) > 64'(pkt)) ? 64'(burst) : 64'(pkt);
                cap_q = cap << TBP_FRAC_BITS;
                pkt_q = 64'(pkt) << TBP_FRAC_BITS;
                if (el != 0)
                begin
                    // Refill saturates at capacity, pulling down a level above it
                    add = (64'(el) * 64'(rate)) >> (RATE_FRAC - TBP_FRAC_BITS);
                    if (lvl >= cap_q || add >= cap_q - lvl)
                        lvl = cap_q;
                    else
                        lvl = lvl + add;
                end
                r.spin = (64'(pkt) * 2 > cap);
                if (lvl >= pkt_q)
                begin
                    lvl       = lvl - pkt_q;
                    r.granted = 1'b1;
                end
                else
                begin
                    two_thirds = (cap_q * 2) / 3;
                    target     = (pkt_q > two_thirds) ? pkt_q : two_thirds;
                    if (rate == 0)
                    begin
                        quo = 64'(MAX_WAIT);
                    end
                    else
                    begin
                        num = (target - lvl) << (RATE_FRAC - TBP_FRAC_BITS);
                        quo = (num + 64'(rate) - 1) / 64'(rate);
                    end
                    if (quo > 64'(MAX_WAIT))
                        quo = 64'(MAX_WAIT);
                    if (quo < 64'(MIN_WAIT))
                        quo = 64'(MIN_WAIT);
                    r.wait_ns = quo[WAIT_W-1:0];
                    last_wait = r.wait_ns;
                end
            end
            level    = lvl[LEVEL_W-1:0];
            r.tokens = lvl[TBP_FRAC_BITS +: PKT_W];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic g, logic [WAIT_W-1:0] w, logic s, logic [PKT_W-1:0] t);
            pacer_result_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display({"%0t unexpected result: expected none, actual ",
                          "granted=%0d wait=%0d spin=%0d tokens=%0d"},
                         $time, g, w, s, t);
            end
            else
            begin
                e = pending_results.pop_front();
                compare("granted", e.granted, g);
                compare("wait_ns", e.wait_ns, w);
                compare("spin_mode", e.spin, s);
                compare("tokens_whole", e.tokens, t);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [CFG_W-1:0]     pwdata;
    logic [CFG_W-1:0]     prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic                 req_type;
    logic [ELAPSED_W-1:0] elapsed_ns;
    logic [PKT_W-1:0]     pkt_len;
    logic                 out_valid;
    logic                 out_ready;
    logic                 granted;
    logic [WAIT_W-1:0]    wait_ns;
    logic                 spin_mode;
    logic [PKT_W-1:0]     tokens_whole;

    // Set for the final phase: both sides run without idling
    bit calm;

    pacer_scoreboard sb = new();

    token_bucket_pacer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .elapsed_ns   (elapsed_ns),
        .pkt_len      (pkt_len),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .wait_ns      (wait_ns),
        .spin_mode    (spin_mode),
        .tokens_whole (tokens_whole)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Present one word, hold it until accepted, then predict it.
    // Now and then drop valid for a random burst afterwards.
    task automatic send_word(input logic req, input logic [ELAPSED_W-1:0] el,
                             input logic [PKT_W-1:0] pkt);
        req_type   <= req;
        elapsed_ns <= el;
        pkt_len    <= pkt;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.pace_word(req, el, pkt);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One APB write, then a read back of the same register
    task automatic cfg_write(input logic sel, input logic [CFG_W-1:0] val);
        logic [CFG_W-1:0] mask;
        mask    = (sel == REG_RATE) ? CFG_W'((64'd1 << RATE_W) - 1)
                                    : CFG_W'((64'd1 << BURST_W) - 1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_RATE)
            sb.rate = val[RATE_W-1:0];
        else
            sb.burst = val[BURST_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.compare("register read", val & mask, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with nothing in flight
    task automatic set_regs(input logic [CFG_W-1:0] rate_v, input logic [CFG_W-1:0] burst_v);
        drain();
        cfg_write(REG_RATE, rate_v);
        cfg_write(REG_BURST, burst_v);
    endtask

    // Receiver: ready bursts, broken by random stalls outside the calm phase
    initial
    begin
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    // Compare every accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(granted, wait_ns, spin_mode, tokens_whole);
    end

    // Watchdog: any handshake on any port restarts the count
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int               p;
        int               k;
        int               pick;
        logic [31:0]      el;
        logic [PKT_W-1:0] pkt;
        logic [PKT_W-1:0] prev_pkt;
        logic [CFG_W-1:0] rate_v;
        logic [CFG_W-1:0] burst_v;

        calm       = 1'b0;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        req_type   <= REQ_SEND;
        elapsed_ns <= '0;
        pkt_len    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: rate 0.125 B/ns, burst 9015
        send_word(REQ_SEND, 0, 0);                     // zero packet always passes
        send_word(REQ_SEND, 0, 16'd9015);              // drain the full bucket
        send_word(REQ_SEND, 0, 16'd100);               // refuse, wait up to 2/3 capacity
        send_word(REQ_SEND, sb.last_wait, 16'd100);    // retry after the reported wait
        send_word(REQ_SEND, 32'hFFFF_FFFF, 16'hFFFF);  // packet over burst sets capacity
        send_word(REQ_RESET, 32'hFFFF_FFFF, 16'hFFFF); // reset ignores both fields
        send_word(REQ_SEND, 1, 16'hFFFF);              // refused, spin flag
        send_word(REQ_SEND, 0, 16'd4508);              // just over half the bucket
        send_word(REQ_SEND, 0, 16'd4507);              // just under half
        send_word(REQ_RESET, 0, 0);

        // Shrink the burst: the level stays, then refill clips it down
        set_regs(RATE_RESET, 32'd100);
        send_word(REQ_SEND, 5, 16'd10);

        // Zero rate: no refill, refusals wait the maximum
        set_regs(32'd0, BURST_RESET);
        send_word(REQ_SEND, 32'd1000, 16'd50);
        send_word(REQ_SEND, 0, 16'd60000);

        // Slowest rate: the wait clamps at the top
        set_regs(32'd1, 32'hFFFF);
        send_word(REQ_SEND, 0, 16'hFFFF);

        // Fastest rate on a one-byte bucket: the wait rounds up to one
        set_regs(32'h0FFF_FFFF, 32'd1);
        send_word(REQ_RESET, 0, 0);
        send_word(REQ_SEND, 0, 16'd1);
        send_word(REQ_SEND, 0, 16'd1);

        // Empty burst
        set_regs(RATE_RESET, 32'd0);
        send_word(REQ_RESET, 32'h1234_5678, 16'h00FF);
        send_word(REQ_SEND, 0, 0);
        send_word(REQ_SEND, 7, 16'd3);

        // Widest burst
        set_regs(RATE_RESET, 32'hFFFF);
        send_word(REQ_RESET, 0, 0);
        send_word(REQ_SEND, 0, 16'hFFFF);

        // Random phases, each under its own rate and burst
        prev_pkt = 16'd1000;
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    rate_v  = RATE_RESET;
                    burst_v = BURST_RESET;
                end
                1:
                begin
                    rate_v  = $urandom_range(32'h0001_0000, 32'h0400_0000);
                    burst_v = $urandom_range(1500, 20000);
                end
                2:
                begin
                    rate_v  = 32'h0FFF_FFFF;
                    burst_v = $urandom_range(1, 2000);
                end
                3:
                begin
                    rate_v  = 32'd1;
                    burst_v = 32'hFFFF;
                end
                default:
                begin
                    rate_v  = $urandom_range(1, 32'h0FFF_FFFF) >> $urandom_range(0, 27);
                    burst_v = $urandom_range(0, 65535) >> $urandom_range(0, 15);
                end
            endcase
            set_regs(rate_v, burst_v);
            calm = (p == 7);
            send_word(REQ_RESET, $urandom, 16'($urandom));
            for (k = 0; k < 127; k++)
            begin
                // Hold off mid-phase until the pipe is empty
                if (p == 1 && k == 64)
                    drain();
                pick = $urandom_range(0, 15);
                if (pick == 0)
                begin
                    send_word(REQ_RESET, $urandom, 16'($urandom));
                end
                else if (pick <= 2)
                begin
                    // Noise: any elapsed time, any packet size
                    pkt = 16'($urandom);
                    send_word(REQ_SEND, $urandom, pkt);
                    prev_pkt = pkt;
                end
                else if (pick <= 6)
                begin
                    // Retry the last packet after the reported wait, or one ns short
                    el = 32'(sb.last_wait);
                    if (el > 0)
                        el = el - $urandom_range(0, 1);
                    send_word(REQ_SEND, el, prev_pkt);
                end
                else if (pick == 7)
                begin
                    pkt = $urandom_range(0, 1500);
                    send_word(REQ_SEND, 0, pkt);
                    prev_pkt = pkt;
                end
                else
                begin
                    pkt = $urandom_range(40, 1500);
                    send_word(REQ_SEND, $urandom_range(0, 4000), pkt);
                    prev_pkt = pkt;
                end
            end
        end

        // Wind down: let every result out, then a little more
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
src/tbp_pkg.sv
src/tbp_ctrl.sv
src/tbp_datapath.sv
src/token_bucket_pacer.sv
tb/sv/token_bucket_pacer_tb.sv
